// ----- rtl/core/lcf_pkg.sv -----
// Package for the light character flasher: widths, status and register codes,
// sequencer opcodes and the microcode table. No dependencies.
`timescale 1ns / 1ps

package lcf_pkg;

   // field and datapath widths
   localparam int unsigned TIME_W  = 64;   // microsecond time
   localparam int unsigned DUR_W   = 32;   // one configured duration
   localparam int unsigned CNT_W   = 8;    // flash count
   localparam int unsigned STEP_W  = 9;    // step index
   localparam int unsigned PITCH_W = DUR_W + 1;           // on + gap
   localparam int unsigned LEN_W   = CNT_W + PITCH_W;     // cycle length
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned PC_W    = 5;
   localparam int unsigned DIV_CNT_W = 6;  // counts the 64 divide steps

   typedef logic [STAT_W-1:0] status_type;
   typedef logic [PC_W-1:0]   pc_type;
   typedef logic [3:0]        op_type;
   typedef logic [3:0]        cond_type;

   // result status codes
   localparam status_type ST_OK           = 2'd0;
   localparam status_type ST_BEFORE_START = 2'd1;
   localparam status_type ST_ZERO_CYCLE   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_ON    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_GAP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE       = 3'd5;

   // register reset values
   localparam logic [CNT_W-1:0]  RST_FLASH_COUNT = 8'd1;
   localparam logic [DUR_W-1:0]  RST_PERIOD      = 32'd1000000;
   localparam logic [DUR_W-1:0]  RST_FLASH_ON    = 32'd300000;
   localparam logic [DUR_W-1:0]  RST_FLASH_GAP   = 32'd500000;

   // datapath operations
   localparam op_type OP_NOP        = 4'd0;
   localparam op_type OP_MUL_FC     = 4'd1;   // mul = count * pitch
   localparam op_type OP_USED       = 4'd2;   // used = mul - gap
   localparam op_type OP_TOTAL      = 4'd3;   // cycle length, step count
   localparam op_type OP_DIV_LOAD   = 4'd4;
   localparam op_type OP_DIV_STEP   = 4'd5;
   localparam op_type OP_SRCH_INIT  = 4'd6;
   localparam op_type OP_SRCH_MUL   = 4'd7;
   localparam op_type OP_SRCH_CMP   = 4'd8;
   localparam op_type OP_END_CALC   = 4'd9;
   localparam op_type OP_START_DONE = 4'd10;
   localparam op_type OP_START_ZERO = 4'd11;
   localparam op_type OP_ADVANCE    = 4'd12;
   localparam op_type OP_HOLD       = 4'd13;

   // jump conditions
   localparam cond_type C_NEXT        = 4'd0;
   localparam cond_type C_ALWAYS      = 4'd1;
   localparam cond_type C_NO_INPUT    = 4'd2;
   localparam cond_type C_IS_UPDATE   = 4'd3;
   localparam cond_type C_ZERO_TOTAL  = 4'd4;
   localparam cond_type C_CNT_NZ      = 4'd5;
   localparam cond_type C_LO_EQ_HI    = 4'd6;
   localparam cond_type C_NOT_STARTED = 4'd7;
   localparam cond_type C_NOT_DUE     = 4'd8;

   // program addresses
   localparam pc_type PC_IDLE        = 5'd0;
   localparam pc_type PC_MUL_FC      = 5'd1;
   localparam pc_type PC_USED        = 5'd2;
   localparam pc_type PC_TOTAL       = 5'd3;
   localparam pc_type PC_DISPATCH    = 5'd4;
   localparam pc_type PC_ZERO_CHK    = 5'd5;
   localparam pc_type PC_DIV_LOAD    = 5'd6;
   localparam pc_type PC_DIV_STEP    = 5'd7;
   localparam pc_type PC_SRCH_INIT   = 5'd8;
   localparam pc_type PC_SRCH_MUL    = 5'd9;
   localparam pc_type PC_SRCH_CMP    = 5'd10;
   localparam pc_type PC_END_CALC    = 5'd11;
   localparam pc_type PC_START_DONE  = 5'd12;
   localparam pc_type PC_START_ZERO  = 5'd13;
   localparam pc_type PC_UPDATE      = 5'd14;
   localparam pc_type PC_UPD_ZERO    = 5'd15;
   localparam pc_type PC_UPD_DUE     = 5'd16;
   localparam pc_type PC_ADVANCE     = 5'd17;
   localparam pc_type PC_HOLD_EARLY  = 5'd18;
   localparam pc_type PC_HOLD_ZERO   = 5'd19;
   localparam pc_type PC_HOLD_OK     = 5'd20;

   // one control word
   typedef struct packed {
      op_type     op;
      cond_type   cond;
      pc_type     target;
      logic       emit;     // step loads the result register
      status_type status;
   } ctrl_type;

   function automatic ctrl_type mk(input op_type op, input cond_type cond,
                                   input pc_type target, input logic emit,
                                   input status_type status);
      ctrl_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      w.emit   = emit;
      w.status = status;
      return w;
   endfunction

   // microcode table
   function automatic ctrl_type ctrl_rom(input pc_type pc);
      ctrl_type w;
      unique case (pc)
         PC_IDLE:       w = mk(OP_NOP,        C_NO_INPUT,    PC_IDLE,       1'b0, ST_OK);
         PC_MUL_FC:     w = mk(OP_MUL_FC,     C_NEXT,        PC_IDLE,       1'b0, ST_OK);
         PC_USED:       w = mk(OP_USED,       C_NEXT,        PC_IDLE,       1'b0, ST_OK);
         PC_TOTAL:      w = mk(OP_TOTAL,      C_NEXT,        PC_IDLE,       1'b0, ST_OK);
         PC_DISPATCH:   w = mk(OP_NOP,        C_IS_UPDATE,   PC_UPDATE,     1'b0, ST_OK);
         PC_ZERO_CHK:   w = mk(OP_NOP,        C_ZERO_TOTAL,  PC_START_ZERO, 1'b0, ST_OK);
         PC_DIV_LOAD:   w = mk(OP_DIV_LOAD,   C_NEXT,        PC_IDLE,       1'b0, ST_OK);
         PC_DIV_STEP:   w = mk(OP_DIV_STEP,   C_CNT_NZ,      PC_DIV_STEP,   1'b0, ST_OK);
         PC_SRCH_INIT:  w = mk(OP_SRCH_INIT,  C_NEXT,        PC_IDLE,       1'b0, ST_OK);
         PC_SRCH_MUL:   w = mk(OP_SRCH_MUL,   C_LO_EQ_HI,    PC_END_CALC,   1'b0, ST_OK);
         PC_SRCH_CMP:   w = mk(OP_SRCH_CMP,   C_ALWAYS,      PC_SRCH_MUL,   1'b0, ST_OK);
         PC_END_CALC:   w = mk(OP_END_CALC,   C_NEXT,        PC_IDLE,       1'b0, ST_OK);
         PC_START_DONE: w = mk(OP_START_DONE, C_ALWAYS,      PC_IDLE,       1'b1, ST_OK);
         PC_START_ZERO: w = mk(OP_START_ZERO, C_ALWAYS,      PC_IDLE,       1'b1,
                               ST_ZERO_CYCLE);
         PC_UPDATE:     w = mk(OP_NOP,        C_NOT_STARTED, PC_HOLD_EARLY, 1'b0, ST_OK);
         PC_UPD_ZERO:   w = mk(OP_NOP,        C_ZERO_TOTAL,  PC_HOLD_ZERO,  1'b0, ST_OK);
         PC_UPD_DUE:    w = mk(OP_NOP,        C_NOT_DUE,     PC_HOLD_OK,    1'b0, ST_OK);
         PC_ADVANCE:    w = mk(OP_ADVANCE,    C_ALWAYS,      PC_IDLE,       1'b1, ST_OK);
         PC_HOLD_EARLY: w = mk(OP_HOLD,       C_ALWAYS,      PC_IDLE,       1'b1,
                               ST_BEFORE_START);
         PC_HOLD_ZERO:  w = mk(OP_HOLD,       C_ALWAYS,      PC_IDLE,       1'b1,
                               ST_ZERO_CYCLE);
         PC_HOLD_OK:    w = mk(OP_HOLD,       C_ALWAYS,      PC_IDLE,       1'b1, ST_OK);
         default:       w = mk(OP_NOP,        C_ALWAYS,      PC_IDLE,       1'b0, ST_OK);
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/light_character_flasher_core.sv -----
// Light character flasher: microcoded sequencer with a shared 8x33 multiplier,
// a bit-serial modulo unit and a binary step search. Depends on lcf_pkg.
`timescale 1ns / 1ps
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  req     | req_tvalid/req_tready  | tuser: action; tdata: now_us
//  rsp     | rsp_tvalid/rsp_tready  | tdata: led_on, step_index, changed, status
//  csr     | csr_we                 | csr_index, csr_wdata
//
//  One item at a time. An update checks the step state against now_us; a start
//  runs the one-bit-a-cycle modulo of the phase-corrected time by the cycle
//  length, then a binary step search (up to 9 probes, each one pass through
//  the shared multiplier). Reset is synchronous and clears the step state and
//  the sequencer, restores the configuration defaults and drops a pending result.
//  A result waits in the output register; the next item is accepted meanwhile,
//  and only a step that writes a new result stalls while that register is full.

module light_character_flasher_core (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // [63:0] now_us
   input  logic        req_tuser,    // [0] action
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [0] led_on, [9:1] step_index, [10] changed,
                                     // [12:11] status, [15:13] zero
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int unsigned TW = lcf_pkg::TIME_W;
   localparam int unsigned DW = lcf_pkg::DUR_W;
   localparam int unsigned CW = lcf_pkg::CNT_W;
   localparam int unsigned SW = lcf_pkg::STEP_W;
   localparam int unsigned PW = lcf_pkg::PITCH_W;
   localparam int unsigned LW = lcf_pkg::LEN_W;
   localparam int unsigned KW = lcf_pkg::DIV_CNT_W;

   // configuration registers
   logic          mode_ff,   mode_in;
   logic [CW-1:0] fc_ff,     fc_in;
   logic [DW-1:0] period_ff, period_in;
   logic [DW-1:0] on_ff,     on_in;
   logic [DW-1:0] gap_ff,    gap_in;
   logic [TW-1:0] offset_ff, offset_in;

   // latched request
   logic          action_ff, action_in;
   logic [TW-1:0] now_ff,    now_in;

   // sequencer and datapath
   lcf_pkg::pc_type pc_ff, pc_in;
   logic [LW-1:0] mul_ff,   mul_in;
   logic [LW-1:0] used_ff,  used_in;
   logic [LW-1:0] total_ff, total_in;
   logic [SW-1:0] n_ff,     n_in;
   logic [TW-1:0] div_ff,   div_in;
   logic [LW-1:0] rem_ff,   rem_in;
   logic [KW-1:0] cnt_ff,   cnt_in;
   logic [SW-1:0] lo_ff,    lo_in;
   logic [SW-1:0] hi_ff,    hi_in;
   logic [SW-1:0] mid_ff,   mid_in;
   logic [LW-1:0] diff_ff,  diff_in;

   // step state
   logic          started_ff, started_in;
   logic [SW-1:0] step_ff,    step_in;
   logic [TW-1:0] next_ff,    next_in;
   logic          level_ff,   level_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_led_ff,   rsp_led_in;
   logic [SW-1:0]         rsp_step_ff,  rsp_step_in;
   logic                  rsp_chg_ff,   rsp_chg_in;
   lcf_pkg::status_type   rsp_stat_ff,  rsp_stat_in;

   lcf_pkg::ctrl_type ctrl;
   logic          exec;
   logic          cond_true;
   logic          accept;
   logic [PW-1:0] pitch;
   logic [SW-1:0] last_idx;
   logic [DW-2:0] half;
   logic [SW:0]   mid_sum;
   logic [SW-1:0] mid;
   logic [CW-1:0] mid_mult;
   logic [CW-1:0] mul_a;
   logic [LW-1:0] prod;
   logic [LW-1:0] step_end;
   logic          used_short;
   logic [LW:0]   trial;
   logic [LW:0]   trial_sub;
   logic [SW:0]   nxt_wide;
   logic [SW-1:0] nxt;
   logic [LW-1:0] remainder_len;
   logic [DW-1:0] nxt_dur;

   // light level of step i
   function automatic logic level_of(input logic [SW-1:0] i, input logic md,
                                     input logic [SW-1:0] last);
      if (!md) return (i == '0);
      if (i >= last) return 1'b0;
      return ~i[0];
   endfunction

   assign ctrl       = lcf_pkg::ctrl_rom(pc_ff);
   assign req_tready = (pc_ff == lcf_pkg::PC_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   // a step that writes the result waits while the old one is not taken
   assign exec       = !(ctrl.emit && rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_stat_ff, rsp_chg_ff, rsp_step_ff, rsp_led_ff};

   // cycle geometry
   assign pitch      = {1'b0, on_ff} + {1'b0, gap_ff};
   assign last_idx   = {fc_ff, 1'b0} - SW'(1);
   assign half       = period_ff[DW-1:1];
   assign used_short = used_ff < {{(LW-DW){1'b0}}, period_ff};

   // search midpoint and the multiplier operand for its step end
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[SW:1];
   assign mid_mult = mid[0] ? (mid[SW-1:1] + CW'(1)) : mid[SW-1:1];
   assign mul_a    = (ctrl.op == lcf_pkg::OP_MUL_FC) ? fc_ff : mid_mult;
   assign prod     = {{(LW-CW){1'b0}}, mul_a} * {{(LW-PW){1'b0}}, pitch};

   // cumulative end of step mid_ff, from the registered product
   always_comb begin
      if (!mode_ff) begin
         step_end = (mid_ff == '0) ? {{(LW-DW+1){1'b0}}, half} : total_ff;
      end else if (mid_ff >= last_idx) begin
         step_end = total_ff;
      end else if (mid_ff[0]) begin
         step_end = mul_ff;
      end else begin
         step_end = mul_ff + {{(LW-DW){1'b0}}, on_ff};
      end
   end

   // one restoring modulo step
   assign trial     = {rem_ff, div_ff[TW-1]};
   assign trial_sub = trial - {1'b0, total_ff};

   // next step on an update, and its duration
   assign nxt_wide      = {1'b0, step_ff} + (SW+1)'(1);
   assign nxt           = (nxt_wide >= {1'b0, n_ff}) ? '0 : nxt_wide[SW-1:0];
   assign remainder_len = {{(LW-DW){1'b0}}, period_ff} - used_ff;
   always_comb begin
      if (!mode_ff)           nxt_dur = {1'b0, half};
      else if (nxt >= last_idx) nxt_dur = remainder_len[DW-1:0];
      else if (nxt[0])        nxt_dur = gap_ff;
      else                    nxt_dur = on_ff;
   end

   // jump condition
   always_comb begin
      unique case (ctrl.cond)
         lcf_pkg::C_NEXT:        cond_true = 1'b0;
         lcf_pkg::C_ALWAYS:      cond_true = 1'b1;
         lcf_pkg::C_NO_INPUT:    cond_true = !accept;
         lcf_pkg::C_IS_UPDATE:   cond_true = action_ff;
         lcf_pkg::C_ZERO_TOTAL:  cond_true = (total_ff == '0);
         lcf_pkg::C_CNT_NZ:      cond_true = (cnt_ff != '0);
         lcf_pkg::C_LO_EQ_HI:    cond_true = (lo_ff == hi_ff);
         lcf_pkg::C_NOT_STARTED: cond_true = !started_ff;
         lcf_pkg::C_NOT_DUE:     cond_true = (now_ff < next_ff);
         default:                cond_true = 1'b0;
      endcase
   end

   // next-state logic
   always_comb begin
      mode_in    = mode_ff;
      fc_in      = fc_ff;
      period_in  = period_ff;
      on_in      = on_ff;
      gap_in     = gap_ff;
      offset_in  = offset_ff;
      action_in  = action_ff;
      now_in     = now_ff;
      pc_in      = pc_ff;
      mul_in     = mul_ff;
      used_in    = used_ff;
      total_in   = total_ff;
      n_in       = n_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      diff_in    = diff_ff;
      started_in = started_ff;
      step_in    = step_ff;
      next_in    = next_ff;
      level_in   = level_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_led_in   = rsp_led_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_stat_in  = rsp_stat_ff;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            lcf_pkg::CSR_MODE:        mode_in   = csr_wdata[0];
            lcf_pkg::CSR_FLASH_COUNT: fc_in     = csr_wdata[CW-1:0];
            lcf_pkg::CSR_PERIOD:      period_in = csr_wdata[DW-1:0];
            lcf_pkg::CSR_FLASH_ON:    on_in     = csr_wdata[DW-1:0];
            lcf_pkg::CSR_FLASH_GAP:   gap_in    = csr_wdata[DW-1:0];
            lcf_pkg::CSR_PHASE:       offset_in = csr_wdata;
            default: ;
         endcase
      end

      // result taken
      if (rsp_tready) rsp_valid_in = 1'b0;

      if (accept) begin
         action_in = req_tuser;
         now_in    = req_tdata;
      end

      if (exec) begin
         pc_in = cond_true ? ctrl.target : pc_ff + lcf_pkg::PC_W'(1);
         if (ctrl.emit) begin
            rsp_valid_in = 1'b1;
            rsp_stat_in  = ctrl.status;
         end

         unique case (ctrl.op)
            lcf_pkg::OP_NOP: ;
            lcf_pkg::OP_MUL_FC: mul_in = prod;
            lcf_pkg::OP_USED: begin
               used_in = (fc_ff == '0) ? '0 : mul_ff - {{(LW-DW){1'b0}}, gap_ff};
            end
            lcf_pkg::OP_TOTAL: begin
               if (!mode_ff) begin
                  total_in = {{(LW-DW){1'b0}}, half, 1'b0};
                  n_in     = SW'(2);
               end else if (fc_ff == '0) begin
                  total_in = '0;
                  n_in     = '0;
               end else begin
                  total_in = used_short ? {{(LW-DW){1'b0}}, period_ff} : used_ff;
                  n_in     = last_idx + {{(SW-1){1'b0}}, used_short};
               end
            end
            lcf_pkg::OP_DIV_LOAD: begin
               div_in = now_ff - offset_ff;
               rem_in = '0;
               cnt_in = '1;
            end
            lcf_pkg::OP_DIV_STEP: begin
               div_in = {div_ff[TW-2:0], 1'b0};
               rem_in = trial_sub[LW] ? trial[LW-1:0] : trial_sub[LW-1:0];
               cnt_in = cnt_ff - KW'(1);
            end
            lcf_pkg::OP_SRCH_INIT: begin
               lo_in = '0;
               hi_in = n_ff - SW'(1);
            end
            lcf_pkg::OP_SRCH_MUL: begin
               mid_in = mid;
               mul_in = prod;
            end
            lcf_pkg::OP_SRCH_CMP: begin
               if (step_end > rem_ff) hi_in = mid_ff;
               else                   lo_in = mid_ff + SW'(1);
            end
            lcf_pkg::OP_END_CALC: diff_in = step_end - rem_ff;
            lcf_pkg::OP_START_DONE: begin
               started_in  = 1'b1;
               step_in     = mid_ff;
               level_in    = level_of(mid_ff, mode_ff, last_idx);
               next_in     = now_ff + {{(TW-LW){1'b0}}, diff_ff};
               rsp_led_in  = level_of(mid_ff, mode_ff, last_idx);
               rsp_step_in = mid_ff;
               rsp_chg_in  = 1'b1;
            end
            lcf_pkg::OP_START_ZERO: begin
               started_in  = 1'b0;
               step_in     = '0;
               level_in    = 1'b0;
               rsp_led_in  = 1'b0;
               rsp_step_in = '0;
               rsp_chg_in  = 1'b0;
            end
            lcf_pkg::OP_ADVANCE: begin
               step_in     = nxt;
               level_in    = level_of(nxt, mode_ff, last_idx);
               next_in     = now_ff + {{(TW-DW){1'b0}}, nxt_dur};
               rsp_led_in  = level_of(nxt, mode_ff, last_idx);
               rsp_step_in = nxt;
               rsp_chg_in  = 1'b1;
            end
            lcf_pkg::OP_HOLD: begin
               rsp_led_in  = level_ff;
               rsp_step_in = step_ff;
               rsp_chg_in  = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // control state and configuration, synchronous reset
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         fc_ff        <= lcf_pkg::RST_FLASH_COUNT;
         period_ff    <= lcf_pkg::RST_PERIOD;
         on_ff        <= lcf_pkg::RST_FLASH_ON;
         gap_ff       <= lcf_pkg::RST_FLASH_GAP;
         offset_ff    <= '0;
         pc_ff        <= lcf_pkg::PC_IDLE;
         started_ff   <= 1'b0;
         step_ff      <= '0;
         next_ff      <= '0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         fc_ff        <= fc_in;
         period_ff    <= period_in;
         on_ff        <= on_in;
         gap_ff       <= gap_in;
         offset_ff    <= offset_in;
         pc_ff        <= pc_in;
         started_ff   <= started_in;
         step_ff      <= step_in;
         next_ff      <= next_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      now_ff      <= now_in;
      mul_ff      <= mul_in;
      used_ff     <= used_in;
      total_ff    <= total_in;
      n_ff        <= n_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      diff_ff     <= diff_in;
      rsp_led_ff  <= rsp_led_in;
      rsp_step_ff <= rsp_step_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_stat_ff <= rsp_stat_in;
   end

endmodule

// ----- rtl/core/lcf_checker.sv -----
// Port-level checks for the light character flasher core, with the bind that
// attaches them. Depends on lcf_pkg and light_character_flasher_core.
`timescale 1ns / 1ps

module lcf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_we,
   input logic [2:0]  csr_index,
   input logic [63:0] csr_wdata
);

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result survives reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // one item at a time: the sequencer leaves idle on accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("second item accepted while busy");

   // a result is never written by the accept or by the first multiply step
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_acc, 1) && !$past(req_acc, 2))
      else $error("result too soon after accept");

   // a step change is only reported with good status
   a_changed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[12:11] == lcf_pkg::ST_OK)
      else $error("changed flagged with error status");

endmodule

bind light_character_flasher_core lcf_checker u_lcf_checker (.*);

// ----- tb/light_character_flasher_core_tb.sv -----
// Self-checking testbench for light_character_flasher_core: directed and random start/update
// words against a cycle-step predictor, with random idling on both stream sides.
// Depends on lcf_pkg and the light_character_flasher_core RTL.
`timescale 1ns / 1ps

module light_character_flasher_core_tb;
   import lcf_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1000000;
   localparam int unsigned SETTLE_CYCLES   = 12;
   localparam int unsigned RANDOM_PHASES   = 14;
   localparam int unsigned WORDS_PER_PHASE = 80;

   localparam logic ACT_START  = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   // register indexes that hold nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic        mode;
      logic [7:0]  count;
      logic [31:0] period;
      logic [31:0] on_us;
      logic [31:0] gap_us;
      logic [63:0] phase;
   } light_cfg_t;

   typedef struct packed {
      logic        started;
      logic [8:0]  step;
      logic [63:0] next_change;
      logic        level;
   } light_state_t;

   typedef struct packed {
      logic        action;
      logic [63:0] now;
   } light_req_t;

   // result word as it sits in rsp_tdata, led_on in bit 0
   typedef struct packed {
      logic [2:0] pad;
      status_type status;
      logic       changed;
      logic [8:0] step;
      logic       led;
   } light_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // [63:0] now_us
   logic        req_tuser = 1'b0;  // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [0] led_on, [9:1] step_index, [10] changed, [12:11] status
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   light_cfg_t   live_cfg;
   light_state_t live_state;   // advanced on every accepted word
   light_state_t plan_state;   // advanced as words are queued, used to aim update times
   light_req_t   pending_reqs[$];
   light_word_t  light_expected[$];

   logic        req_taken = 1'b0;
   logic        steady = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_gap = 0;
   logic [63:0] last_now = '0;

   int unsigned cycle_count = 0;
   int unsigned pushed_count = 0;
   int unsigned accepted_count = 0;
   int unsigned start_words = 0;
   int unsigned update_words = 0;
   int unsigned advances = 0;
   int unsigned zero_words = 0;
   int unsigned early_words = 0;
   int unsigned cfg_writes = 0;
   int unsigned mismatches = 0;
   int unsigned p;

   light_character_flasher_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- step arithmetic

   // lit time plus gaps of one group
   function automatic logic [63:0] flash_span_used(input light_cfg_t c);
      if (c.count == 8'd0) return 64'd0;
      return 64'(c.count) * 64'(c.on_us) + 64'(c.count - 8'd1) * 64'(c.gap_us);
   endfunction

   function automatic int unsigned step_count(input light_cfg_t c);
      if (!c.mode) return 2;
      if (c.count == 8'd0) return 0;
      return 2 * c.count - 1 + ((flash_span_used(c) < 64'(c.period)) ? 1 : 0);
   endfunction

   function automatic logic [63:0] cycle_len(input light_cfg_t c);
      logic [63:0] used;
      if (!c.mode) return 64'(c.period >> 1) * 64'd2;
      if (c.count == 8'd0) return 64'd0;
      used = flash_span_used(c);
      return (used < 64'(c.period)) ? 64'(c.period) : used;
   endfunction

   function automatic logic [63:0] step_len(input light_cfg_t c, input int unsigned i);
      if (!c.mode) return 64'(c.period >> 1);
      if (i >= 2 * c.count - 1) return 64'(c.period) - flash_span_used(c);
      return (i % 2 != 0) ? 64'(c.gap_us) : 64'(c.on_us);
   endfunction

   function automatic logic step_lit(input light_cfg_t c, input int unsigned i);
      if (!c.mode) return i == 0;
      if (i >= 2 * c.count - 1) return 1'b0;
      return i % 2 == 0;
   endfunction

   // next result word and state for one accepted word
   function automatic light_word_t light_predict(inout light_state_t st, input light_cfg_t c,
                                                 input logic action, input logic [63:0] now);
      light_word_t w;
      logic [63:0] total, elapsed, acc;
      int unsigned n, k, hit_step, nxt;
      logic        hit;
      total = cycle_len(c);
      n = step_count(c);
      w = '0;
      w.status = ST_OK;
      if (action == ACT_START) begin
         if (total == 64'd0) begin
            st.started = 1'b0;
            st.step = '0;
            st.level = 1'b0;
            w.status = ST_ZERO_CYCLE;
         end else begin
            // first step whose running end lies past the phase-corrected time
            elapsed = (now - c.phase) % total;
            acc = '0;
            hit = 1'b0;
            hit_step = 0;
            for (k = 0; k < n; k++) begin
               if (!hit) begin
                  acc += step_len(c, k);
                  if (elapsed < acc) begin
                     hit = 1'b1;
                     hit_step = k;
                  end
               end
            end
            st.step = 9'(hit_step);
            st.level = step_lit(c, hit_step);
            st.next_change = now + (acc - elapsed);
            st.started = 1'b1;
            w.changed = 1'b1;
         end
      end else if (!st.started) begin
         w.status = ST_BEFORE_START;
      end else if (total == 64'd0) begin
         w.status = ST_ZERO_CYCLE;
      end else if (now >= st.next_change) begin
         nxt = st.step + 1;
         if (nxt >= n) nxt = 0;
         st.step = 9'(nxt);
         st.level = step_lit(c, nxt);
         st.next_change = now + step_len(c, nxt);
         w.changed = 1'b1;
      end
      w.led = st.level;
      w.step = st.step;
      return w;
   endfunction

   // ---------------------------------------------------------------- random helpers

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] pick_span();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return '1;
         2, 3:    return $urandom_range(1, 20);
         4, 5, 6: return $urandom_range(1, 100000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd1;
         8, 9:    return $urandom_range(0, 255);
         default: return $urandom_range(2, 6);
      endcase
   endfunction

   function automatic logic [63:0] pick_phase();
      case ($urandom_range(0, 3))
         0:       return 64'd0;
         1:       return '1;
         default: return rand64();
      endcase
   endfunction

   // unused upper bits of a register write get random junk now and then
   function automatic logic [63:0] with_junk(input logic [63:0] val, input int unsigned width);
      logic [63:0] keep;
      keep = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
      if ($urandom_range(0, 2) == 0) return (val & keep) | (rand64() & ~keep);
      return val & keep;
   endfunction

   // ---------------------------------------------------------------- stimulus tasks

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MODE:        live_cfg.mode = val[0];
         CSR_FLASH_COUNT: live_cfg.count = val[7:0];
         CSR_PERIOD:      live_cfg.period = val[31:0];
         CSR_FLASH_ON:    live_cfg.on_us = val[31:0];
         CSR_FLASH_GAP:   live_cfg.gap_us = val[31:0];
         CSR_PHASE:       live_cfg.phase = val;
         default: ;
      endcase
      cfg_writes++;
   endtask

   task automatic load_config(input logic mode, input logic [7:0] count,
                              input logic [31:0] period, input logic [31:0] on_us,
                              input logic [31:0] gap_us, input logic [63:0] phase);
      csr_write(CSR_MODE, with_junk(64'(mode), 1));
      csr_write(CSR_FLASH_COUNT, with_junk(64'(count), 8));
      csr_write(CSR_PERIOD, with_junk(64'(period), 32));
      csr_write(CSR_FLASH_ON, with_junk(64'(on_us), 32));
      csr_write(CSR_FLASH_GAP, with_junk(64'(gap_us), 32));
      csr_write(CSR_PHASE, phase);
   endtask

   task automatic queue_req(input logic action, input logic [63:0] now);
      light_req_t  r;
      light_word_t ignored;
      r.action = action;
      r.now = now;
      pending_reqs.push_back(r);
      ignored = light_predict(plan_state, live_cfg, action, now);
      pushed_count++;
      last_now = now;
   endtask

   // mostly updates aimed at the scheduled change, some starts and stray times
   task automatic random_words(input int unsigned count);
      int unsigned k, pick;
      logic [63:0] t;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8 || (!plan_state.started && pick < 40)) begin
            t = ($urandom_range(0, 3) == 0) ? rand64() : last_now + $urandom_range(0, 50);
            queue_req(ACT_START, t);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: t = plan_state.next_change;
               4:          t = plan_state.next_change - 64'd1;
               5, 6:       t = plan_state.next_change + $urandom_range(1, 1000);
               7:          t = last_now + $urandom_range(0, 3);
               8:          t = rand64();
               default:    t = last_now;
            endcase
            queue_req(ACT_UPDATE, t);
         end
      end
   endtask

   // block idle: every queued word taken and answered
   task automatic wait_idle();
      @(posedge clock);
      #1;
      while (pushed_count != accepted_count || light_expected.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : drive_words
      light_req_t r;
      logic       v, rdy;
      r.action = req_tuser;
      r.now = req_tdata;
      v = req_tvalid;
      // a word on offer stays until taken
      if (!req_tvalid || req_taken) begin
         if (req_gap != 0) begin
            req_gap--;
            v = 1'b0;
         end else if (pending_reqs.size() == 0) begin
            v = 1'b0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            req_gap = $urandom_range(0, 4);
            v = 1'b0;
         end else begin
            r = pending_reqs.pop_front();
            v = 1'b1;
         end
      end
      req_taken = 1'b0;
      // receiver stalls
      rdy = 1'b1;
      if (rsp_gap != 0) begin
         rsp_gap--;
         rdy = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_gap = $urandom_range(0, 4);
         rdy = 1'b0;
      end
      req_tvalid <= v;
      req_tdata <= r.now;
      req_tuser <= r.action;
      rsp_tready <= rdy;
   end

   // ---------------------------------------------------------------- monitor and checker

   always @(posedge clock) begin : watch_words
      light_word_t want, got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  light_expected.size());
         $display("** light_character_flasher_core: FAILED **");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = light_predict(live_state, live_cfg, req_tuser, req_tdata);
            light_expected.push_back(want);
            accepted_count++;
            req_taken = 1'b1;
            if (req_tuser == ACT_START) start_words++;
            else update_words++;
            if (req_tuser == ACT_UPDATE && want.changed) advances++;
            if (want.status == ST_ZERO_CYCLE) zero_words++;
            if (want.status == ST_BEFORE_START) early_words++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (light_expected.size() == 0) begin
               mismatches++;
               $display("%0t: result word with nothing expected, expected none, got %0h",
                        $time, rsp_tdata);
            end else begin
               want = light_expected.pop_front();
               check_field("led_on", want.led, got.led);
               check_field("step_index", want.step, got.step);
               check_field("changed", want.changed, got.changed);
               check_field("status", want.status, got.status);
               check_field("pad bits", want.pad, got.pad);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      live_cfg.mode = 1'b0;
      live_cfg.count = RST_FLASH_COUNT;
      live_cfg.period = RST_PERIOD;
      live_cfg.on_us = RST_FLASH_ON;
      live_cfg.gap_us = RST_FLASH_GAP;
      live_cfg.phase = '0;
      live_state = '0;
      plan_state = '0;

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // isophase at reset values: early update, start, boundary and wrapping updates
      queue_req(ACT_UPDATE, 64'd0);
      queue_req(ACT_START, 64'd0);
      queue_req(ACT_UPDATE, plan_state.next_change - 64'd1);
      queue_req(ACT_UPDATE, plan_state.next_change);
      queue_req(ACT_UPDATE, '1);
      queue_req(ACT_UPDATE, plan_state.next_change);
      wait_idle();

      // indexes with no register behind them
      csr_write(CSR_SPARE_LO, rand64());
      csr_write(CSR_SPARE_HI, rand64());

      // isophase period below two while started, then a start clears it
      load_config(1'b0, 8'd1, 32'd1, 32'd300000, 32'd500000, 64'd0);
      queue_req(ACT_UPDATE, 64'd5);
      queue_req(ACT_START, 64'd7);
      queue_req(ACT_UPDATE, 64'd9);
      wait_idle();

      // odd period, phase larger than the start time
      load_config(1'b0, 8'd1, 32'd3, 32'd0, 32'd0, '1);
      queue_req(ACT_START, 64'd0);
      queue_req(ACT_UPDATE, plan_state.next_change);
      wait_idle();

      // most steps: 255 flashes plus remainder, start inside the remainder
      load_config(1'b1, 8'd255, 32'd1000, 32'd1, 32'd1, 64'd0);
      queue_req(ACT_START, 64'd999);
      queue_req(ACT_UPDATE, plan_state.next_change);
      queue_req(ACT_START, 64'd2);
      wait_idle();

      // all durations at maximum: flashes overrun the period, start on the last step
      load_config(1'b1, 8'd255, '1, '1, '1, '1);
      queue_req(ACT_START, live_cfg.phase + cycle_len(live_cfg) - 64'd1);
      queue_req(ACT_UPDATE, plan_state.next_change);
      wait_idle();

      // group with no flashes
      load_config(1'b1, 8'd0, 32'd1000, 32'd5, 32'd5, 64'd0);
      queue_req(ACT_START, rand64());
      queue_req(ACT_UPDATE, rand64());
      wait_idle();

      // all durations zero, then zero-length flashes before a short remainder
      load_config(1'b1, 8'd3, 32'd0, 32'd0, 32'd0, 64'd0);
      queue_req(ACT_START, 64'd100);
      wait_idle();
      csr_write(CSR_PERIOD, 64'd4);
      queue_req(ACT_START, 64'd0);
      queue_req(ACT_UPDATE, plan_state.next_change);
      queue_req(ACT_UPDATE, plan_state.next_change);
      queue_req(ACT_UPDATE, plan_state.next_change);
      wait_idle();

      // one flash exactly fills the period: a one-step cycle
      load_config(1'b1, 8'd1, 32'd5, 32'd5, '1, 64'd0);
      queue_req(ACT_START, 64'd3);
      queue_req(ACT_UPDATE, plan_state.next_change);
      wait_idle();

      // random phases; state carries over each register change
      for (p = 0; p < RANDOM_PHASES; p++) begin
         steady = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 4) == 0);
         case (p)
            0:       load_config(1'b1, 8'd255, '1, 32'd1, 32'd1, rand64());
            1:       load_config(1'b0, 8'd0, '1, '1, '1, '1);
            2:       load_config(1'b1, 8'd2, 32'd0, 32'd0, 32'd3, 64'd0);
            default: load_config($urandom_range(0, 1), pick_count(), pick_span(), pick_span(),
                                 pick_span(), pick_phase());
         endcase
         random_words(WORDS_PER_PHASE);
         wait_idle();
      end

      $display("run covered %0d words: %0d starts, %0d updates, %0d step advances", accepted_count,
               start_words, update_words, advances);
      $display("%0d zero-cycle and %0d early results over %0d register writes, %0d mismatches",
               zero_words, early_words, cfg_writes, mismatches);
      if (mismatches == 0) begin
         $display("** light_character_flasher_core: PASSED **");
      end else begin
         $display("** light_character_flasher_core: FAILED **");
      end
      $finish;
   end

endmodule
